// ----- rtl/dspx_pkg.sv -----
// ----------------------------------------------------------------------------
// dspx_pkg
// Types and constants shared by the execute stage: opcodes, run states,
// bus access codes, the decoded instruction and the transfer payloads.
// ----------------------------------------------------------------------------
package dspx_pkg;

  localparam int REG_COUNT = 16;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int DATA_W    = 32;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    CMD_NOP   = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_STORE = 3'd2,
    CMD_ADD   = 3'd3,
    CMD_MUL   = 3'd4,
    CMD_MAC   = 3'd5,
    CMD_OUT   = 3'd6,
    CMD_HALT  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    RUN_GO     = 2'd0,
    RUN_HALTED = 2'd1,
    RUN_ERROR  = 2'd2
  } run_t;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } acc_t;

  typedef enum logic [3:0] {
    OP_LOAD_IMM,
    OP_LOAD_BUS,
    OP_STORE,
    OP_ADD,
    OP_MUL,
    OP_MAC,
    OP_OUT,
    OP_HALT,
    OP_ILLEGAL
  } op_t;

  typedef struct packed {
    logic [2:0]               command;
    logic [REG_AW-1:0]        reg_a;
    logic [REG_AW-1:0]        reg_b;
    logic [REG_AW-1:0]        reg_c;
    logic                     use_immediate;
    logic signed [DATA_W-1:0] immediate;
    logic signed [DATA_W-1:0] bus_read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               bus_access;
    logic signed [DATA_W-1:0] bus_address;
    logic signed [DATA_W-1:0] bus_write_data;
    logic                     gpio_valid;
    logic signed [DATA_W-1:0] gpio_pin;
    logic signed [DATA_W-1:0] gpio_value;
    logic                     flag_zero;
    logic                     flag_negative;
    logic                     flag_carry;
    logic [1:0]               run_status;
  } out_item_t;

  typedef struct packed {
    op_t                      op;
    logic [REG_AW-1:0]        reg_a;
    logic [REG_AW-1:0]        reg_b;
    logic [REG_AW-1:0]        reg_c;
    logic signed [DATA_W-1:0] immediate;
    logic signed [DATA_W-1:0] bus_read_data;
  } dec_item_t;

endpackage

// ----- rtl/dspx_in_if.sv -----
// ----------------------------------------------------------------------------
// dspx_in_if
// Instruction channel: valid/ready handshake with a decoded instruction.
// ----------------------------------------------------------------------------
interface dspx_in_if;
  import dspx_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/dspx_out_if.sv -----
// ----------------------------------------------------------------------------
// dspx_out_if
// Result channel: valid/ready handshake with bus, gpio, flag and run status.
// ----------------------------------------------------------------------------
interface dspx_out_if;
  import dspx_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/dsp_instruction_execute.sv -----
// ----------------------------------------------------------------------------
// dsp_instruction_execute
// Execute stage of a small DSP core: one decoded instruction in, one result
// out, with 16 signed 32-bit registers and zero, negative, carry flags.
//
// instr carries one decoded instruction per transfer; result carries one
// item per instruction with the bus access, gpio write, flags after the
// instruction and run status. Both use valid/ready.
// A result passes through the front queue, the register file read register,
// then the result register. Throughput is one instruction per cycle while
// result is not stalled, set by the single execute step (register read,
// 32x32 multiply and 64-bit add, register write).
// A 4-entry queue lets instructions keep arriving while result is stalled;
// instr.ready falls only once the queue is full. Stalls on either side lose
// or repeat nothing.
// Reset (rst, synchronous) empties the queue, clears the flags, sets the
// core running and marks every register as zero; no clearing pass is needed.
// After HALT, NOP or an unknown opcode the core ignores instructions and
// reports the held flags and run status.
// ----------------------------------------------------------------------------
module dsp_instruction_execute (
  input  logic       clk,
  input  logic       rst,
  dspx_in_if.sink    instr,
  dspx_out_if.source result
);
  import dspx_pkg::*;

  logic      q_valid;
  logic      q_ready;
  dec_item_t q_item;

  dspx_front u_front (
    .clk     (clk),
    .rst     (rst),
    .instr   (instr),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  dspx_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .result  (result)
  );

endmodule

// ----- rtl/dspx_front.sv -----
// ----------------------------------------------------------------------------
// dspx_front
// Accepts instructions, classifies them into execute operations and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module dspx_front (
  input  logic                clk,
  input  logic                rst,
  dspx_in_if.sink             instr,
  output logic                q_valid,
  input  logic                q_ready,
  output dspx_pkg::dec_item_t q_item
);
  import dspx_pkg::*;

  dec_item_t      q_mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  dec_item_t      dec;
  logic           push;
  logic           pop;

  always_comb begin
    dec.reg_a         = instr.data.reg_a;
    dec.reg_b         = instr.data.reg_b;
    dec.reg_c         = instr.data.reg_c;
    dec.immediate     = instr.data.immediate;
    dec.bus_read_data = instr.data.bus_read_data;
    unique case (cmd_t'(instr.data.command))
      CMD_LOAD:  dec.op = instr.data.use_immediate ? OP_LOAD_IMM : OP_LOAD_BUS;
      CMD_STORE: dec.op = OP_STORE;
      CMD_ADD:   dec.op = OP_ADD;
      CMD_MUL:   dec.op = OP_MUL;
      CMD_MAC:   dec.op = OP_MAC;
      CMD_OUT:   dec.op = OP_OUT;
      CMD_HALT:  dec.op = OP_HALT;
      default:   dec.op = OP_ILLEGAL;
    endcase
  end

  assign instr.ready = (count != (QAW+1)'(QDEPTH));
  assign push        = instr.valid && instr.ready;
  assign q_valid     = (count != '0);
  assign pop         = q_valid && q_ready;
  assign q_item      = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= dec;
  end

endmodule

// ----- rtl/dspx_back.sv -----
// ----------------------------------------------------------------------------
// dspx_back
// Executes queued operations: register file read, multiply-add, flag and
// run state update, and the registered result.
// ----------------------------------------------------------------------------
module dspx_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  dspx_pkg::dec_item_t q_item,
  dspx_out_if.source          result
);
  import dspx_pkg::*;

  // three copies of the register file, one read port each
  logic [DATA_W-1:0] mem_a [REG_COUNT];
  logic [DATA_W-1:0] mem_b [REG_COUNT];
  logic [DATA_W-1:0] mem_c [REG_COUNT];
  logic [REG_COUNT-1:0] reg_ok;

  logic              adv;
  logic              pop;
  logic              r_valid;
  dec_item_t         r_item;
  logic [DATA_W-1:0] r_rd_a;
  logic [DATA_W-1:0] r_rd_b;
  logic [DATA_W-1:0] r_rd_c;
  logic              r_ok_a;
  logic              r_ok_b;
  logic              r_ok_c;

  logic              fwd_valid;
  logic [REG_AW-1:0] fwd_addr;
  logic [DATA_W-1:0] fwd_data;

  logic              zf;
  logic              nf;
  logic              cf;
  run_t              run;
  logic              zf_next;
  logic              nf_next;
  logic              cf_next;
  run_t              run_next;

  logic              out_valid;
  out_item_t         out_data;
  out_item_t         out_next;

  logic signed [DATA_W-1:0] a_val;
  logic signed [DATA_W-1:0] b_val;
  logic signed [DATA_W-1:0] c_val;
  logic signed [63:0]       prod;
  logic signed [63:0]       opx;
  logic signed [63:0]       opy;
  logic signed [63:0]       exact;
  logic                     ovf;
  logic                     wr_en;
  logic [DATA_W-1:0]        wr_data;

  assign adv     = !out_valid || result.ready;
  assign q_ready = adv;
  assign pop     = q_valid && adv;

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // operand values with bypass of the write made at the capture edge
  always_comb begin
    a_val = r_ok_a ? r_rd_a : '0;
    b_val = r_ok_b ? r_rd_b : '0;
    c_val = r_ok_c ? r_rd_c : '0;
    if (fwd_valid && fwd_addr == r_item.reg_a) a_val = fwd_data;
    if (fwd_valid && fwd_addr == r_item.reg_b) b_val = fwd_data;
    if (fwd_valid && fwd_addr == r_item.reg_c) c_val = fwd_data;
  end

  assign prod = 64'(b_val) * 64'(c_val);

  always_comb begin
    unique case (r_item.op)
      OP_ADD: begin
        opx = 64'(b_val);
        opy = 64'(c_val);
      end
      OP_MAC: begin
        opx = 64'(a_val);
        opy = prod;
      end
      default: begin
        opx = '0;
        opy = prod;
      end
    endcase
  end

  assign exact = opx + opy;
  assign ovf   = !((&exact[63:31]) || !(|exact[63:31]));

  always_comb begin
    wr_en    = 1'b0;
    wr_data  = exact[DATA_W-1:0];
    cf_next  = cf;
    run_next = run;
    out_next = '0;
    if (r_valid && run == RUN_GO) begin
      unique case (r_item.op)
        OP_LOAD_IMM: begin
          wr_en   = 1'b1;
          wr_data = r_item.immediate;
          cf_next = 1'b0;
        end
        OP_LOAD_BUS: begin
          wr_en                = 1'b1;
          wr_data              = r_item.bus_read_data;
          cf_next              = 1'b0;
          out_next.bus_access  = ACC_READ;
          out_next.bus_address = r_item.immediate;
        end
        OP_STORE: begin
          out_next.bus_access     = ACC_WRITE;
          out_next.bus_address    = a_val;
          out_next.bus_write_data = b_val;
        end
        OP_ADD, OP_MUL, OP_MAC: begin
          wr_en   = 1'b1;
          cf_next = ovf;
        end
        OP_OUT: begin
          out_next.gpio_valid = 1'b1;
          out_next.gpio_pin   = a_val;
          out_next.gpio_value = b_val;
        end
        OP_HALT: run_next = RUN_HALTED;
        default: run_next = RUN_ERROR;
      endcase
    end
    zf_next = wr_en ? (wr_data == '0) : zf;
    nf_next = wr_en ? wr_data[DATA_W-1] : nf;
    out_next.flag_zero     = zf_next;
    out_next.flag_negative = nf_next;
    out_next.flag_carry    = cf_next;
    out_next.run_status    = run_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid   <= 1'b0;
      out_valid <= 1'b0;
      fwd_valid <= 1'b0;
      reg_ok    <= '0;
      zf        <= 1'b0;
      nf        <= 1'b0;
      cf        <= 1'b0;
      run       <= RUN_GO;
    end else if (adv) begin
      r_valid   <= pop;
      out_valid <= r_valid;
      fwd_valid <= wr_en;
      zf        <= zf_next;
      nf        <= nf_next;
      cf        <= cf_next;
      run       <= run_next;
      if (wr_en) reg_ok[r_item.reg_a] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_item   <= q_item;
      r_ok_a   <= reg_ok[q_item.reg_a];
      r_ok_b   <= reg_ok[q_item.reg_b];
      r_ok_c   <= reg_ok[q_item.reg_c];
      fwd_addr <= r_item.reg_a;
      fwd_data <= wr_data;
      out_data <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_rd_a <= mem_a[q_item.reg_a];
      r_rd_b <= mem_b[q_item.reg_b];
      r_rd_c <= mem_c[q_item.reg_c];
      if (wr_en) begin
        mem_a[r_item.reg_a] <= wr_data;
        mem_b[r_item.reg_a] <= wr_data;
        mem_c[r_item.reg_a] <= wr_data;
      end
    end
  end

endmodule
